// File: rtl/rrmqd_pkg.sv
// Types and constants for the round-robin multi-queue buffer with overflow drop.
// Used by round_robin_multi_queue_dropper; depends on nothing else.
package rrmqd_pkg;

  localparam int unsigned CamW   = 3;
  localparam int unsigned VidW   = 8;
  localparam int unsigned WordW  = 64;
  localparam int unsigned CfgW   = 5;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CFG_FILL_LIMIT  = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_DROP_AMOUNT = 1'd1;

  localparam logic [CfgW-1:0] FILL_LIMIT_RST  = 5'd25;
  localparam logic [CfgW-1:0] DROP_AMOUNT_RST = 5'd15;
  localparam logic [CfgW-1:0] BUFFERED_MAX    = 5'd31;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [CamW-1:0]  camera;
    logic [VidW-1:0]  vehicle_id;
    logic [WordW-1:0] entry_data;
  } req_t;

  typedef struct packed {
    logic             out_valid;
    logic [CamW-1:0]  out_camera;
    logic [VidW-1:0]  out_vehicle_id;
    logic [WordW-1:0] out_data;
    logic [CfgW-1:0]  dropped;
    logic [CfgW-1:0]  buffered;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_DROP,
    ST_SEARCH,
    ST_RESP
  } state_e;

endpackage

// File: rtl/round_robin_multi_queue_dropper.sv
// Round-robin multi-queue buffer with overflow drop: per-camera FIFOs in one memory,
// a small sequencer walks the queues one per cycle. Depends on rrmqd_pkg.
//
// A push to a valid camera passes through the push and response steps, plus one drop step
// per queue visited in a drop burst (up to drop_amount passes over the span); a pop visits
// queues in the search step, skipping empty ones (at most span - 1), then responds, or
// responds at once with nothing held. One item at a time: busy stays high until the result
// is registered, and no new request is taken before then. Reset clears all counts,
// pointers and the span; the entry memory is not cleared. done_o pulses for one cycle.
module round_robin_multi_queue_dropper #(
  parameter int unsigned NUM_CAMERAS = 8,
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned DATA_WIDTH  = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  rrmqd_pkg::req_t                     req_i,
  output logic                                done_o,
  output rrmqd_pkg::rsp_t                     res_o,
  input  logic                                cfg_we_i,
  input  logic [rrmqd_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [rrmqd_pkg::CfgW-1:0]          cfg_wdata_i
);

  localparam int unsigned CamW   = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;
  localparam int unsigned SpanW  = $clog2(NUM_CAMERAS + 1);
  localparam int unsigned QpW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QcW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SumW   = QpW + 1;
  localparam int unsigned Entries = NUM_CAMERAS * QUEUE_DEPTH;
  localparam int unsigned AddrW  = $clog2(Entries);
  localparam int unsigned TotW   = $clog2(Entries + 1);
  localparam int unsigned MemW   = rrmqd_pkg::VidW + DATA_WIDTH;

  rrmqd_pkg::state_e state_q, state_d;

  logic [QpW-1:0]  head_q [NUM_CAMERAS];
  logic [QcW-1:0]  cnt_q  [NUM_CAMERAS];
  logic [TotW-1:0] total_q, total_d;
  logic [CamW-1:0] rr_q, rr_d;
  logic [SpanW-1:0] span_q, span_d;
  logic [CamW-1:0] q_q, q_d;
  logic [rrmqd_pkg::CfgW-1:0] fill_q, drop_q;
  logic [rrmqd_pkg::CfgW-1:0] target_q, target_d;
  logic [rrmqd_pkg::CfgW-1:0] dcnt_q, dcnt_d;
  logic hit_q, hit_d;
  logic [rrmqd_pkg::VidW-1:0] vid_q;
  logic [DATA_WIDTH-1:0]      data_q;
  logic                       is_push_q, is_push_d;

  logic done_q;
  rrmqd_pkg::rsp_t res_q, res_d;

  logic [MemW-1:0] mem [Entries];
  logic [MemW-1:0] rdata_q;
  logic            mem_we, mem_re;
  logic [AddrW-1:0] mem_addr;

  logic inc_en, dec_en;
  logic [QpW-1:0]  head_cur, head_nxt;
  logic [QcW-1:0]  cnt_cur;
  logic [SumW-1:0] slot_sum;
  logic [QpW-1:0]  slot;
  logic [CamW-1:0] q_next, rr_next;
  logic [TotW-1:0] tot_inc;
  logic            cam_ok, over;
  logic [rrmqd_pkg::CfgW-1:0] tgt_new;

  assign head_cur = head_q[q_q];
  assign cnt_cur  = cnt_q[q_q];
  assign head_nxt = (SumW'(head_cur) + SumW'(1) == SumW'(QUEUE_DEPTH)) ? '0 : head_cur + 1'b1;
  assign slot_sum = SumW'(head_cur) + SumW'(cnt_cur);
  assign slot     = (slot_sum >= SumW'(QUEUE_DEPTH)) ? QpW'(slot_sum - SumW'(QUEUE_DEPTH))
                                                     : QpW'(slot_sum);
  assign q_next   = (SpanW'(q_q) + SpanW'(1) == span_q) ? '0 : q_q + 1'b1;
  assign rr_next  = (SpanW'(rr_q) + SpanW'(1) == span_q) ? '0 : rr_q + 1'b1;
  assign tot_inc  = total_q + 1'b1;
  assign cam_ok   = 32'(req_i.camera) < NUM_CAMERAS;
  assign over     = 32'(tot_inc) > 32'(fill_q);
  assign tgt_new  = (32'(drop_q) < 32'(tot_inc)) ? drop_q : rrmqd_pkg::CfgW'(tot_inc);

  assign busy = (state_q != rrmqd_pkg::ST_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rrmqd_pkg::ST_IDLE: begin
        if (start) begin
          if (req_i.req_type == rrmqd_pkg::REQ_PUSH) begin
            state_d = cam_ok ? rrmqd_pkg::ST_PUSH : rrmqd_pkg::ST_RESP;
          end else if (total_q != '0 && span_q != '0) begin
            state_d = rrmqd_pkg::ST_SEARCH;
          end else begin
            state_d = rrmqd_pkg::ST_RESP;
          end
        end
      end
      rrmqd_pkg::ST_PUSH: begin
        if (32'(cnt_cur) < QUEUE_DEPTH && over && tgt_new != '0) begin
          state_d = rrmqd_pkg::ST_DROP;
        end else begin
          state_d = rrmqd_pkg::ST_RESP;
        end
      end
      rrmqd_pkg::ST_DROP: begin
        if (cnt_cur != '0 && dcnt_q + 1'b1 == target_q) state_d = rrmqd_pkg::ST_RESP;
      end
      rrmqd_pkg::ST_SEARCH: begin
        if (cnt_cur != '0) state_d = rrmqd_pkg::ST_RESP;
      end
      rrmqd_pkg::ST_RESP: state_d = rrmqd_pkg::ST_IDLE;
      default: state_d = rrmqd_pkg::ST_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    q_d       = q_q;
    rr_d      = rr_q;
    span_d    = span_q;
    total_d   = total_q;
    target_d  = target_q;
    dcnt_d    = dcnt_q;
    hit_d     = hit_q;
    is_push_d = is_push_q;
    inc_en    = 1'b0;
    dec_en    = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = AddrW'(q_q) * AddrW'(QUEUE_DEPTH) + AddrW'(slot);
    res_d     = res_q;
    unique case (state_q)
      rrmqd_pkg::ST_IDLE: begin
        if (start) begin
          dcnt_d    = '0;
          hit_d     = 1'b0;
          is_push_d = (req_i.req_type == rrmqd_pkg::REQ_PUSH);
          if (req_i.req_type == rrmqd_pkg::REQ_PUSH) begin
            if (cam_ok) begin
              q_d = CamW'(req_i.camera);
              if (SpanW'(req_i.camera) + SpanW'(1) > span_q) begin
                span_d = SpanW'(req_i.camera) + SpanW'(1);
              end
            end
          end else begin
            q_d = rr_next;
          end
        end
      end
      rrmqd_pkg::ST_PUSH: begin
        if (32'(cnt_cur) < QUEUE_DEPTH) begin
          mem_we   = 1'b1;
          inc_en   = 1'b1;
          total_d  = tot_inc;
          target_d = tgt_new;
          // burst starts at the round-robin pointer
          q_d      = rr_q;
        end
      end
      rrmqd_pkg::ST_DROP: begin
        if (cnt_cur != '0) begin
          dec_en  = 1'b1;
          total_d = total_q - 1'b1;
          dcnt_d  = dcnt_q + 1'b1;
        end
        q_d = q_next;
      end
      rrmqd_pkg::ST_SEARCH: begin
        mem_addr = AddrW'(q_q) * AddrW'(QUEUE_DEPTH) + AddrW'(head_cur);
        if (cnt_cur != '0) begin
          mem_re  = 1'b1;
          dec_en  = 1'b1;
          total_d = total_q - 1'b1;
          rr_d    = q_q;
          hit_d   = 1'b1;
        end else begin
          q_d = q_next;
        end
      end
      rrmqd_pkg::ST_RESP: begin
        res_d.out_valid      = hit_q;
        res_d.out_camera     = hit_q ? rrmqd_pkg::CamW'(q_q) : '0;
        res_d.out_vehicle_id = hit_q ? rdata_q[MemW-1 -: rrmqd_pkg::VidW] : '0;
        res_d.out_data       = hit_q ? rrmqd_pkg::WordW'(rdata_q[DATA_WIDTH-1:0]) : '0;
        res_d.dropped        = is_push_q ? dcnt_q : '0;
        res_d.buffered       = (32'(total_q) > 32'(rrmqd_pkg::BUFFERED_MAX))
                               ? rrmqd_pkg::BUFFERED_MAX : rrmqd_pkg::CfgW'(total_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rrmqd_pkg::ST_IDLE;
      total_q   <= '0;
      rr_q      <= '0;
      span_q    <= '0;
      q_q       <= '0;
      target_q  <= '0;
      dcnt_q    <= '0;
      hit_q     <= 1'b0;
      is_push_q <= 1'b0;
      done_q    <= 1'b0;
      fill_q    <= rrmqd_pkg::FILL_LIMIT_RST;
      drop_q    <= rrmqd_pkg::DROP_AMOUNT_RST;
      for (int i = 0; i < NUM_CAMERAS; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      rr_q      <= rr_d;
      span_q    <= span_d;
      q_q       <= q_d;
      target_q  <= target_d;
      dcnt_q    <= dcnt_d;
      hit_q     <= hit_d;
      is_push_q <= is_push_d;
      done_q    <= (state_q == rrmqd_pkg::ST_RESP);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rrmqd_pkg::CFG_FILL_LIMIT:  fill_q <= cfg_wdata_i;
          rrmqd_pkg::CFG_DROP_AMOUNT: drop_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (inc_en) begin
        cnt_q[q_q] <= cnt_cur + 1'b1;
      end else if (dec_en) begin
        cnt_q[q_q]  <= cnt_cur - 1'b1;
        head_q[q_q] <= head_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == rrmqd_pkg::ST_IDLE && start) begin
      vid_q  <= req_i.vehicle_id;
      data_q <= req_i.entry_data[DATA_WIDTH-1:0];
    end
  end

  // Entry memory: one write or one read per cycle, registered read data
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= {vid_q, data_q};
    if (mem_re) rdata_q <= mem[mem_addr];
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_after_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == rrmqd_pkg::ST_RESP))
    else $error("result strobe without a response step");

  a_rr_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (span_q != '0) |-> (SpanW'(rr_q) < span_q))
    else $error("round-robin pointer outside the camera span");

  a_drop_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rrmqd_pkg::ST_DROP) |-> (target_q != '0 && dcnt_q < target_q))
    else $error("drop burst overran its target");

  a_pop_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.out_valid) |-> (res_q.dropped == '0))
    else $error("popped item reports dropped entries");

  a_search_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rrmqd_pkg::ST_SEARCH) |-> (total_q != '0))
    else $error("queue search with no entries held");

endmodule
